@@ hw/rtl/dts_tok_pkg.sv @@
// dts_tok_pkg: widths, token and mode codes, character constants and
// character class helpers for the device-tree source tokenizer.
// Standalone package, used by dts_text_tokenizer_top.
package dts_tok_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LINE_BITS     = 20;
    localparam int LENGTH_BITS   = 16;
    localparam int VALUE_BITS    = 32;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    typedef logic [3:0] kind_t;

    localparam kind_t K_END    = 4'd0;
    localparam kind_t K_LBRACE = 4'd1;
    localparam kind_t K_RBRACE = 4'd2;
    localparam kind_t K_SEMI   = 4'd3;
    localparam kind_t K_EQ     = 4'd4;
    localparam kind_t K_COMMA  = 4'd5;
    localparam kind_t K_COLON  = 4'd6;
    localparam kind_t K_LT     = 4'd7;
    localparam kind_t K_GT     = 4'd8;
    localparam kind_t K_STRING = 4'd9;
    localparam kind_t K_IDENT  = 4'd10;
    localparam kind_t K_REF    = 4'd11;
    localparam kind_t K_SLASH  = 4'd12;
    localparam kind_t K_ERROR  = 4'd13;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_SLASH     = 4'd1,
        M_LINE      = 4'd2,
        M_BLOCK     = 4'd3,
        M_STAR      = 4'd4,
        M_STRING    = 4'd5,
        M_IDENT     = 4'd6,
        M_REF_FIRST = 4'd7,
        M_REF       = 4'd8,
        M_ERROR     = 4'd9
    } mode_t;

    // number flags: bit 0 leading zero, bit 1 hex, bit 2 decimal stopped
    localparam int F_ZERO = 0;
    localparam int F_HEX  = 1;
    localparam int F_STOP = 2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        kind_t                    kind;
        logic [LINE_BITS-1:0]     line;
        logic [POSITION_BITS-1:0] start;
        logic [LENGTH_BITS-1:0]   length;
        logic [VALUE_BITS-1:0]    value;
        logic                     last;
    } token_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  acc;
        logic [2:0]             flags;
        logic [LENGTH_BITS-1:0] length;
    } word_state_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) ||
               c inside {CH_UNDER, CH_MINUS, CH_DOT, CH_COMMA, CH_AT,
                         CH_HASH, CH_PLUS, CH_QMARK};
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c inside {CH_UNDER, CH_HASH};
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_sat_inc(
        input logic [LENGTH_BITS-1:0] v);
        return (v == {LENGTH_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic token_t make_token(
        input kind_t                    kind,
        input logic [LINE_BITS-1:0]     line,
        input logic [POSITION_BITS-1:0] start,
        input logic [LENGTH_BITS-1:0]   length,
        input logic [VALUE_BITS-1:0]    value);
        token_t t;
        t.kind   = kind;
        t.line   = line;
        t.start  = start;
        t.length = length;
        t.value  = value;
        t.last   = 1'b0;
        return t;
    endfunction

    // one identifier character into the number reader
    function automatic word_state_t feed_word(input word_state_t ws,
                                              input logic [7:0] c);
        word_state_t r;
        logic [VALUE_BITS-1:0] x16;
        logic [VALUE_BITS-1:0] x10;
        r   = ws;
        x16 = {ws.acc[VALUE_BITS-5:0], 4'd0};
        x10 = {ws.acc[VALUE_BITS-4:0], 3'd0} + {ws.acc[VALUE_BITS-2:0], 1'b0};
        if (ws.length == '0) begin
            if (c == CH_ZERO) r.flags[F_ZERO] = 1'b1;
            if (is_digit(c)) r.acc = VALUE_BITS'(c - CH_ZERO);
            else r.flags[F_STOP] = 1'b1;
        end else if (ws.flags[F_HEX]) begin
            if (is_digit(c)) r.acc = x16 + VALUE_BITS'(c - CH_ZERO);
            else if (c inside {[CH_LC_A:CH_LC_F]})
                r.acc = x16 + VALUE_BITS'(c - CH_LC_A + 8'd10);
            else if (c inside {[CH_UC_A:CH_UC_F]})
                r.acc = x16 + VALUE_BITS'(c - CH_UC_A + 8'd10);
        end else if (ws.length == LENGTH_BITS'(1) && ws.flags[F_ZERO] &&
                     (c == CH_LC_X || c == CH_UC_X)) begin
            r.flags[F_HEX] = 1'b1;
            r.acc          = '0;
        end else if (!ws.flags[F_STOP]) begin
            if (is_digit(c)) r.acc = x10 + VALUE_BITS'(c - CH_ZERO);
            else r.flags[F_STOP] = 1'b1;
        end
        r.length = len_sat_inc(ws.length);
        return r;
    endfunction

endpackage

@@ hw/rtl/dts_text_tokenizer_top.sv @@
// dts_text_tokenizer_top: device-tree source lexer, one text byte per item,
// up to two tokens per byte through a small token queue.
// Depends on dts_tok_pkg.
//
//  channel   dir  ports                                  carries
//  s_        in   s_valid s_ready s_text_byte            one source byte
//  m_        out  m_valid m_ready m_token_kind ...       one token
//
// A byte is held in the input register, then the lexer updates its
// state and writes zero, one or two tokens into a four-entry token queue.
// One byte per cycle while the queue holds at most two tokens; the single
// queue read port delivers one token per cycle while m_ready is high, so
// the two tokens of one byte leave the queue one after the other.
// Synchronous active-low reset puts the lexer between tokens at line 1,
// position 0, and empties the queue. m_ready low fills the queue and then
// stalls the input register and s_ready.
module dts_text_tokenizer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_text_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [3:0]                         m_token_kind,
    output logic [dts_tok_pkg::LINE_BITS-1:0]     m_token_line,
    output logic [dts_tok_pkg::POSITION_BITS-1:0] m_text_start,
    output logic [dts_tok_pkg::LENGTH_BITS-1:0]   m_text_length,
    output logic [dts_tok_pkg::VALUE_BITS-1:0]    m_number_value,
    output logic                               m_last_of_run
);
    import dts_tok_pkg::*;

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [LINE_BITS-1:0]     line_count_reg, line_count_next;
    logic [POSITION_BITS-1:0] start_pos_reg, start_pos_next;
    logic [LINE_BITS-1:0]     start_line_reg, start_line_next;
    word_state_t              word_reg, word_next;

    token_t                   fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [FIFO_PTR_BITS:0]   fifo_count_reg;

    logic                     fire;
    logic                     pop;
    logic [1:0]               emit_n;
    token_t                   tok0, tok1;
    token_t                   head;

    assign fire    = in_valid_reg && (fifo_count_reg <= (FIFO_PTR_BITS+1)'(2));
    assign s_ready = aresetn && (!in_valid_reg || fire);
    assign pop     = m_valid && m_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
    end

    // lexer: next state and the tokens this byte produces
    always_comb begin
        logic [7:0]               c;
        logic [POSITION_BITS-1:0] pos;
        logic                     do_idle;
        logic                     restart;
        logic [LINE_BITS-1:0]     line_inc;
        token_t                   t;
        logic                     have_t;
        token_t                   ti;
        logic                     have_ti;
        word_state_t              fresh;

        c        = in_byte_reg;
        pos      = byte_pos_reg;
        do_idle  = 1'b0;
        restart  = 1'b0;
        line_inc = (line_count_reg == {LINE_BITS{1'b1}}) ? line_count_reg
                                                         : line_count_reg + 1'b1;
        t        = make_token(K_END, '0, '0, '0, '0);
        have_t   = 1'b0;
        ti       = make_token(K_END, '0, '0, '0, '0);
        have_ti  = 1'b0;
        fresh    = '0;

        mode_next       = mode_reg;
        byte_pos_next   = pos + 1'b1;
        line_count_next = line_count_reg;
        start_pos_next  = start_pos_reg;
        start_line_next = start_line_reg;
        word_next       = word_reg;

        case (mode_reg)
            M_SLASH: begin
                if (c == CH_SLASH) mode_next = M_LINE;
                else if (c == CH_STAR) mode_next = M_BLOCK;
                else begin
                    t = make_token(K_SLASH, start_line_reg, start_pos_reg, '0, '0);
                    have_t  = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_LINE: begin
                if (c == CH_NUL || c == CH_LF) do_idle = 1'b1;
            end
            M_BLOCK, M_STAR: begin
                if (c == CH_NUL) do_idle = 1'b1;
                else if (c == CH_SLASH && mode_reg == M_STAR) mode_next = M_IDLE;
                else if (c == CH_STAR) mode_next = M_STAR;
                else begin
                    if (c == CH_LF) line_count_next = line_inc;
                    mode_next = M_BLOCK;
                end
            end
            M_STRING: begin
                if (c == CH_NUL) begin
                    t = make_token(K_ERROR, line_count_reg, pos, '0, '0);
                    have_t  = 1'b1;
                    restart = 1'b1;
                end else if (c == CH_QUOTE) begin
                    t = make_token(K_STRING, start_line_reg, start_pos_reg,
                                   word_reg.length, '0);
                    have_t    = 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    if (c == CH_LF) line_count_next = line_inc;
                    word_next.length = len_sat_inc(word_reg.length);
                end
            end
            M_IDENT: begin
                if (is_word(c)) word_next = feed_word(word_reg, c);
                else begin
                    t = make_token(K_IDENT, start_line_reg, start_pos_reg,
                                   word_reg.length, word_reg.acc);
                    have_t  = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_REF_FIRST: begin
                if (is_word(c)) begin
                    word_next.length = LENGTH_BITS'(1);
                    mode_next        = M_REF;
                end else begin
                    t = make_token(K_ERROR, line_count_reg, pos, '0, '0);
                    have_t = 1'b1;
                    if (c == CH_NUL) restart = 1'b1;
                    else mode_next = M_ERROR;
                end
            end
            M_REF: begin
                if (is_word(c)) word_next.length = len_sat_inc(word_reg.length);
                else begin
                    t = make_token(K_REF, start_line_reg, start_pos_reg,
                                   word_reg.length, '0);
                    have_t  = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_ERROR: begin
                if (c == CH_NUL) restart = 1'b1;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // byte handled as if between tokens
        if (do_idle) begin
            mode_next = M_IDLE;
            case (c)
                CH_NUL: begin
                    ti = make_token(K_END, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                    restart = 1'b1;
                end
                CH_SPACE, CH_TAB, CH_CR: ;
                CH_LF:     line_count_next = line_inc;
                CH_LBRACE: begin
                    ti      = make_token(K_LBRACE, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_RBRACE: begin
                    ti      = make_token(K_RBRACE, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_SEMI: begin
                    ti      = make_token(K_SEMI, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_EQ: begin
                    ti      = make_token(K_EQ, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_COMMA: begin
                    ti      = make_token(K_COMMA, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_COLON: begin
                    ti      = make_token(K_COLON, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_LT: begin
                    ti      = make_token(K_LT, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_GT: begin
                    ti      = make_token(K_GT, line_count_reg, pos, '0, '0);
                    have_ti = 1'b1;
                end
                CH_SLASH: begin
                    mode_next       = M_SLASH;
                    start_pos_next  = pos;
                    start_line_next = line_count_reg;
                end
                CH_AMP, CH_QUOTE: begin
                    mode_next        = (c == CH_AMP) ? M_REF_FIRST : M_STRING;
                    start_pos_next   = pos + 1'b1;
                    start_line_next  = line_count_reg;
                    word_next.length = '0;
                end
                CH_BSLASH: begin
                    ti = make_token(K_IDENT, line_count_reg, pos, LENGTH_BITS'(1), '0);
                    have_ti = 1'b1;
                end
                default: begin
                    if (is_word_start(c)) begin
                        mode_next       = M_IDENT;
                        start_pos_next  = pos;
                        start_line_next = line_count_reg;
                        word_next       = feed_word(fresh, c);
                    end else begin
                        mode_next = M_ERROR;
                        ti = make_token(K_ERROR, line_count_reg, pos, '0, '0);
                        have_ti = 1'b1;
                    end
                end
            endcase
        end

        if (restart) begin
            mode_next       = M_IDLE;
            byte_pos_next   = '0;
            line_count_next = LINE_BITS'(1);
            start_pos_next  = '0;
            start_line_next = LINE_BITS'(1);
            word_next       = '0;
        end

        // pack emitted tokens into slots, mark the last one
        emit_n = 2'(have_t) + 2'(have_ti);
        tok0   = have_t ? t : ti;
        tok1   = ti;
        if (have_t && have_ti) tok1.last = 1'b1;
        else tok0.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            byte_pos_reg   <= '0;
            line_count_reg <= LINE_BITS'(1);
            start_pos_reg  <= '0;
            start_line_reg <= LINE_BITS'(1);
            word_reg       <= '0;
        end else if (fire) begin
            mode_reg       <= mode_next;
            byte_pos_reg   <= byte_pos_next;
            line_count_reg <= line_count_next;
            start_pos_reg  <= start_pos_next;
            start_line_reg <= start_line_next;
            word_reg       <= word_next;
        end
    end

    // token queue: two write slots, one read
    always_ff @(posedge aclk) begin
        if (fire && emit_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= tok0;
        end
        if (fire && emit_n == 2'd2) begin
            fifo_mem[wr_ptr_reg + 1'b1] <= tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (fire) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(emit_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_count_reg <= fifo_count_reg
                              + (fire ? (FIFO_PTR_BITS+1)'(emit_n) : '0)
                              - (FIFO_PTR_BITS+1)'(pop);
        end
    end

    always_comb begin
        head           = fifo_mem[rd_ptr_reg];
        m_valid        = (fifo_count_reg != '0);
        m_token_kind   = head.kind;
        m_token_line   = head.line;
        m_text_start   = head.start;
        m_text_length  = head.length;
        m_number_value = head.value;
        m_last_of_run  = head.last;
    end

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_count_reg <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH))
        else $error("token queue overflow");

    // first token of a pair always has its partner queued behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> fifo_count_reg >= (FIFO_PTR_BITS+1)'(2))
        else $error("first token of a pair without its partner");

    // a zero byte restarts position and line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_byte_reg == CH_NUL) |=>
            (byte_pos_reg == '0 && line_count_reg == LINE_BITS'(1)))
        else $error("text not restarted after end byte");

    // bytes after an error produce nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && mode_reg == M_ERROR) |-> emit_n == 2'd0)
        else $error("token emitted while skipping after error");

endmodule
